// File: sv/bces_pkg.sv
package bces_pkg;

   // defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_WINDOW_DEF = 15;
   localparam int PIXEL_BITS_DEF = 8;

   // fixed geometry of the register and result fields
   localparam int MAX_HEIGHT    = 1024;
   localparam int ROW_BITS      = 10;
   localparam int COORD_BITS    = 10;
   localparam int GEOM_BITS     = 11;
   localparam int SIZE_BITS     = 4;
   localparam int THR_BITS      = 17;
   localparam int THR_ONE       = 65536;
   localparam int Q_FRAC        = 16;
   localparam int CSR_ADDR_BITS = 2;
   localparam int RSP_DATA_BITS = 24;

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int SIZE_RESET   = 5;
   localparam int THR_RESET    = 32768;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_WINDOW_SIZE  = 2'd2,
      CSR_THRESHOLD    = 2'd3
   } csr_index_type;

   // per-pixel control flags handed from front to back
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic sub_win;    // window complete along the row: retire oldest column
      logic have_old;   // window complete down the column: drop oldest row
      logic unit_win;   // window side of one
      logic emit;       // a result goes out for this pixel
      logic done;       // last pixel of the frame
   } item_flags_type;

endpackage

// File: sv/bces_ram.sv
module bces_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bces_queue.sv
module bces_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head      = slot_ff[rd_ptr_ff];

endmodule

// File: sv/bces_front.sv
module bces_front #(
   parameter int MAX_WIDTH  = bces_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = bces_pkg::MAX_WINDOW_DEF,
   parameter int PIXEL_BITS = bces_pkg::PIXEL_BITS_DEF,
   localparam int CW    = $clog2(MAX_WIDTH),
   localparam int LINES = MAX_WINDOW - 1,
   localparam int LW    = $clog2(LINES),
   localparam int RAW   = $clog2(LINES * MAX_WIDTH),
   localparam int SW    = $clog2(MAX_WINDOW + 1),
   localparam int KW    = $clog2(MAX_WINDOW)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [PIXEL_BITS-1:0]               pixel,
   input  logic                                frame_start,
   input  logic [bces_pkg::GEOM_BITS-1:0]      frame_width,
   input  logic [bces_pkg::GEOM_BITS-1:0]      frame_height,
   input  logic [bces_pkg::SIZE_BITS-1:0]      window_size,
   input  logic [bces_pkg::THR_BITS-1:0]       threshold_q16,
   input  logic                                queue_full,
   output logic                                push,
   output bces_pkg::item_flags_type            flags,
   output logic [PIXEL_BITS-1:0]               pix,
   output logic [CW-1:0]                       col,
   output logic [RAW-1:0]                      wr_addr,
   output logic [RAW-1:0]                      rd_addr,
   output logic [KW-1:0]                       rk,
   output logic [KW-1:0]                       ok,
   output logic [bces_pkg::COORD_BITS-1:0]     out_row,
   output logic [bces_pkg::COORD_BITS-1:0]     out_col,
   output logic [bces_pkg::THR_BITS-1:0]       thr,
   output logic [2*SW-1:0]                     s2
);

   localparam int XW = (bces_pkg::GEOM_BITS > CW + 1) ? bces_pkg::GEOM_BITS : CW + 1;
   localparam int GW = bces_pkg::GEOM_BITS;

   logic [bces_pkg::ROW_BITS-1:0] row_ff, row_in;
   logic [CW-1:0]                 col_ff, col_in;
   logic [LW-1:0]                 line_ff, line_in;
   logic [KW-1:0]                 rk_ff, rk_in;
   logic [SW-1:0]                 s_ff, s_in;

   logic [bces_pkg::ROW_BITS-1:0] r;
   logic [CW-1:0]                 c;
   logic [LW-1:0]                 line;
   logic [SW-1:0]                 s, s_clamp, half, s_m1;
   logic [XW-1:0]                 fw, wv, c1;
   logic [GW-1:0]                 hv, r1;
   logic [LW:0]                   old_line;
   logic [KW:0]                   ok_wide;
   logic                          last_col, last_row, accept;

   always_comb begin
      accept = in_valid && in_ready;
      r      = frame_start ? '0 : row_ff;
      c      = frame_start ? '0 : col_ff;
      line   = frame_start ? '0 : line_ff;
      rk     = frame_start ? '0 : rk_ff;

      s_clamp = (int'(window_size) > MAX_WINDOW) ? SW'(MAX_WINDOW) : SW'(window_size);
      s       = (r == '0 && c == '0) ? s_clamp : s_ff;
      s_m1    = s - SW'(1);
      half    = s_m1 >> 1;

      fw = XW'(frame_width);
      if (fw == '0) begin
         wv = XW'(1);
      end else if (fw > XW'(MAX_WIDTH)) begin
         wv = XW'(MAX_WIDTH);
      end else begin
         wv = fw;
      end
      if (frame_height == '0) begin
         hv = GW'(1);
      end else if (frame_height > GW'(bces_pkg::MAX_HEIGHT)) begin
         hv = GW'(bces_pkg::MAX_HEIGHT);
      end else begin
         hv = frame_height;
      end

      c1       = XW'(c) + XW'(1);
      r1       = GW'(r) + GW'(1);
      last_col = c1 >= wv;
      last_row = r1 >= hv;

      flags.first_row = r == '0;
      flags.first_col = c == '0;
      flags.sub_win   = c1 >= XW'(s);
      flags.have_old  = r1 >= GW'(s);
      flags.unit_win  = s == SW'(1);
      flags.emit      = flags.sub_win && flags.have_old;
      flags.done      = last_row && last_col;

      out_row = bces_pkg::COORD_BITS'(r1 - GW'(s) + GW'(half));
      out_col = bces_pkg::COORD_BITS'(c1 - XW'(s) + XW'(half));

      // line holding row r+1-s, ring of LINES rows
      old_line = (LW+1)'(line) + (LW+1)'(LINES) - (LW+1)'(s_m1);
      if (old_line >= (LW+1)'(LINES)) begin
         old_line = old_line - (LW+1)'(LINES);
      end
      // recent-column slot of column c+1-s, ring of MAX_WINDOW
      ok_wide = (KW+1)'(rk) + (KW+1)'(MAX_WINDOW) - (KW+1)'(s_m1);
      if (ok_wide >= (KW+1)'(MAX_WINDOW)) begin
         ok_wide = ok_wide - (KW+1)'(MAX_WINDOW);
      end
      ok = KW'(ok_wide);

      wr_addr = RAW'(line) * RAW'(MAX_WIDTH) + RAW'(c);
      rd_addr = RAW'(old_line) * RAW'(MAX_WIDTH) + RAW'(c);

      thr = (threshold_q16 > bces_pkg::THR_BITS'(bces_pkg::THR_ONE))
            ? bces_pkg::THR_BITS'(bces_pkg::THR_ONE) : threshold_q16;
      s2  = (2*SW)'(s) * (2*SW)'(s);
      pix = pixel;
      col = c;

      in_ready = !queue_full;
      push     = accept && (s != '0);

      s_in = s;
      if (last_col) begin
         col_in = '0;
         rk_in  = '0;
         if (last_row) begin
            row_in  = '0;
            line_in = '0;
         end else begin
            row_in  = r + bces_pkg::ROW_BITS'(1);
            line_in = (line == LW'(LINES - 1)) ? '0 : line + LW'(1);
         end
      end else begin
         col_in  = c + CW'(1);
         rk_in   = (rk == KW'(MAX_WINDOW - 1)) ? '0 : rk + KW'(1);
         row_in  = r;
         line_in = line;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         line_ff <= '0;
         rk_ff   <= '0;
         s_ff    <= '0;
      end else if (accept) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         line_ff <= line_in;
         rk_ff   <= rk_in;
         s_ff    <= s_in;
      end
   end

endmodule

// File: sv/bces_back.sv
module bces_back #(
   parameter int MAX_WIDTH  = bces_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = bces_pkg::MAX_WINDOW_DEF,
   parameter int PIXEL_BITS = bces_pkg::PIXEL_BITS_DEF,
   localparam int CW    = $clog2(MAX_WIDTH),
   localparam int LINES = MAX_WINDOW - 1,
   localparam int RAW   = $clog2(LINES * MAX_WIDTH),
   localparam int SW    = $clog2(MAX_WINDOW + 1),
   localparam int KW    = $clog2(MAX_WINDOW)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   output logic                            pop,
   input  bces_pkg::item_flags_type        flags,
   input  logic [PIXEL_BITS-1:0]           pix,
   input  logic [CW-1:0]                   col,
   input  logic [RAW-1:0]                  wr_addr,
   input  logic [RAW-1:0]                  rd_addr,
   input  logic [KW-1:0]                   rk,
   input  logic [KW-1:0]                   ok,
   input  logic [bces_pkg::COORD_BITS-1:0] out_row,
   input  logic [bces_pkg::COORD_BITS-1:0] out_col,
   input  logic [bces_pkg::THR_BITS-1:0]   thr,
   input  logic [2*SW-1:0]                 s2,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_edge,
   output logic [bces_pkg::COORD_BITS-1:0] rsp_row,
   output logic [bces_pkg::COORD_BITS-1:0] rsp_col,
   output logic                            rsp_done
);

   localparam longint unsigned PMAX = (64'd1 << PIXEL_BITS) - 64'd1;
   localparam longint unsigned MWL  = 64'(MAX_WINDOW);
   localparam int CS_W  = $clog2(MWL * PMAX + 64'd1);
   localparam int SQ_W  = $clog2(MWL * PMAX * PMAX + 64'd1);
   localparam int WS_W  = $clog2(MWL * MWL * PMAX + 64'd1);
   localparam int WQ_W  = $clog2(MWL * MWL * PMAX * PMAX + 64'd1);
   localparam int TS_W  = bces_pkg::THR_BITS + 2 * SW;
   localparam int LHS_W = 2 * WS_W + bces_pkg::Q_FRAC;
   localparam int RHS_W = TS_W + WQ_W;
   localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_UPD  = 5'b00010,
      ST_MUL1 = 5'b00100,
      ST_MUL2 = 5'b01000,
      ST_OUT  = 5'b10000
   } back_state_type;

   back_state_type st_ff, st_in;

   bces_pkg::item_flags_type              flags_ff;
   logic [PIXEL_BITS-1:0]                 pix_ff;
   logic [CW-1:0]                         col_ff;
   logic [RAW-1:0]                        wr_ff;
   logic [KW-1:0]                         rk_ff, ok_ff;
   logic [bces_pkg::COORD_BITS-1:0]       row_ff, ocol_ff;
   logic [bces_pkg::THR_BITS-1:0]         thr_ff;
   logic [2*SW-1:0]                       s2_ff;

   logic [WS_W-1:0]  ws_ff, b_ff;
   logic [WQ_W-1:0]  wq_ff, q_ff;
   logic [CS_W-1:0]  recent_cs_ff [MAX_WINDOW];
   logic [SQ_W-1:0]  recent_sq_ff [MAX_WINDOW];
   logic [2*WS_W-1:0] p1_ff;
   logic [TS_W-1:0]  ts_ff;
   logic [CMP_W-1:0] lhs_ff, rhs_ff;

   logic                            rsp_valid_ff;
   logic                            edge_ff, done_ff;
   logic [bces_pkg::COORD_BITS-1:0] orow_out_ff, ocol_out_ff;

   // column sum RAM holds {square sum, sum}
   logic [CS_W+SQ_W-1:0] cs_rd, cs_wd;
   logic [PIXEL_BITS-1:0] rs_rd, old;
   logic [CS_W-1:0] full, cs_new, sub_cs;
   logic [SQ_W-1:0] fullq, sq_new, sub_sq, pix_sq, old_sq;
   logic [WS_W-1:0] bsum;
   logic [WQ_W-1:0] bsq;
   logic            upd, load_out;

   always_comb begin
      pop      = (st_ff == ST_IDLE) && item_valid;
      upd      = st_ff == ST_UPD;
      load_out = (st_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

      pix_sq = SQ_W'(pix_ff) * SQ_W'(pix_ff);
      old    = flags_ff.unit_win ? pix_ff : rs_rd;
      old_sq = SQ_W'(old) * SQ_W'(old);
      full   = (flags_ff.first_row ? '0 : cs_rd[CS_W-1:0]) + CS_W'(pix_ff);
      fullq  = (flags_ff.first_row ? '0 : cs_rd[CS_W +: SQ_W]) + pix_sq;
      cs_new = flags_ff.have_old ? full - CS_W'(old) : full;
      sq_new = flags_ff.have_old ? fullq - old_sq : fullq;
      cs_wd  = {sq_new, cs_new};

      bsum = (flags_ff.first_col ? '0 : ws_ff) + WS_W'(full);
      bsq  = (flags_ff.first_col ? '0 : wq_ff) + WQ_W'(fullq);
      // the slot being retired may be the one written this cycle
      sub_cs = (ok_ff == rk_ff) ? full : recent_cs_ff[ok_ff];
      sub_sq = (ok_ff == rk_ff) ? fullq : recent_sq_ff[ok_ff];

      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (item_valid) st_in = ST_UPD;
         ST_UPD:  st_in = flags_ff.emit ? ST_MUL1 : ST_IDLE;
         ST_MUL1: st_in = ST_MUL2;
         ST_MUL2: st_in = ST_OUT;
         ST_OUT:  if (load_out) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   bces_ram #(.WIDTH(CS_W + SQ_W), .DEPTH(MAX_WIDTH)) u_col_ram (
      .clock   (clock),
      .wr_en   (upd),
      .wr_addr (col_ff),
      .wr_data (cs_wd),
      .rd_en   (pop),
      .rd_addr (col),
      .rd_data (cs_rd)
   );

   bces_ram #(.WIDTH(PIXEL_BITS), .DEPTH(LINES * MAX_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (upd),
      .wr_addr (wr_ff),
      .wr_data (pix_ff),
      .rd_en   (pop),
      .rd_addr (rd_addr),
      .rd_data (rs_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         flags_ff <= flags;
         pix_ff   <= pix;
         col_ff   <= col;
         wr_ff    <= wr_addr;
         rk_ff    <= rk;
         ok_ff    <= ok;
         row_ff   <= out_row;
         ocol_ff  <= out_col;
         thr_ff   <= thr;
         s2_ff    <= s2;
      end
      if (upd) begin
         recent_cs_ff[rk_ff] <= full;
         recent_sq_ff[rk_ff] <= fullq;
         b_ff  <= bsum;
         q_ff  <= bsq;
         ws_ff <= bsum - (flags_ff.sub_win ? WS_W'(sub_cs) : '0);
         wq_ff <= bsq - (flags_ff.sub_win ? WQ_W'(sub_sq) : '0);
      end
      if (st_ff == ST_MUL1) begin
         p1_ff <= (2*WS_W)'(b_ff) * (2*WS_W)'(b_ff);
         ts_ff <= TS_W'(thr_ff) * TS_W'(s2_ff);
      end
      if (st_ff == ST_MUL2) begin
         lhs_ff <= CMP_W'(p1_ff) << bces_pkg::Q_FRAC;
         rhs_ff <= CMP_W'(RHS_W'(ts_ff) * RHS_W'(q_ff));
      end
      if (load_out) begin
         edge_ff     <= lhs_ff < rhs_ff;
         orow_out_ff <= row_ff;
         ocol_out_ff <= ocol_ff;
         done_ff     <= flags_ff.done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_edge  = edge_ff;
   assign rsp_row   = orow_out_ff;
   assign rsp_col   = ocol_out_ff;
   assign rsp_done  = done_ff;

   a_emit_path: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_UPD && flags_ff.emit) |=>
      (st_ff == ST_MUL1) ##1 (st_ff == ST_MUL2) ##1 (st_ff == ST_OUT))
      else $error("emitting word left the compare path");

   a_quiet_path: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_UPD && !flags_ff.emit) |=> (st_ff == ST_IDLE))
      else $error("non-emitting word did not retire");

   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff == ST_OUT))
      else $error("result raised outside compare stage");

endmodule

// File: sv/box_contrast_edge_segmenter_unit.sv
// Channel | Dir | Handshake            | Word
// req     | in  | req_tvalid/tready    | tdata: pixel; tuser: frame_start
// rsp     | out | rsp_tvalid/tready    | tdata: edge_res,out_row,out_col; tlast: frame_done
// csr     | in  | csr_valid/csr_ready  | csr_addr: register index; csr_wdata: value
//
// Flow: a word whose window side is zero is never queued for the back end. Any other
// word passes the back end's column RAM read, then its update, plus the two multiply
// stages and the compare when it emits a result; the back end takes no new word until
// the last is done, bounded by the single-port-per-direction column and line RAMs and the shared multipliers.
// Reset clears position, window latch, queue and output valid; no RAM clearing
// pass is needed, the first row of a frame ignores stored column sums.
// A stalled rsp side fills the output register, then the 2-word queue, then
// drops req_tready; csr writes are always taken.
module box_contrast_edge_segmenter_unit #(
   parameter int MAX_WIDTH  = bces_pkg::MAX_WIDTH_DEF,
   parameter int MAX_WINDOW = bces_pkg::MAX_WINDOW_DEF,
   parameter int PIXEL_BITS = bces_pkg::PIXEL_BITS_DEF,
   localparam int REQ_BITS = ((PIXEL_BITS + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req: pixel in the low bits
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [REQ_BITS-1:0]                  req_tdata,
   input  logic                                 req_tuser,   // frame_start
   // rsp: [0] edge_res, [10:1] out_row, [20:11] out_col, rest zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bces_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,   // frame_done
   // csr write port
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bces_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [bces_pkg::THR_BITS-1:0]        csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int LINES = MAX_WINDOW - 1;
   localparam int RAW   = $clog2(LINES * MAX_WIDTH);
   localparam int SW    = $clog2(MAX_WINDOW + 1);
   localparam int KW    = $clog2(MAX_WINDOW);
   localparam int CB    = bces_pkg::COORD_BITS;
   localparam int FLW   = $bits(bces_pkg::item_flags_type);
   localparam int QW    = FLW + PIXEL_BITS + CW + 2 * RAW + 2 * KW + 2 * CB
                          + bces_pkg::THR_BITS + 2 * SW;

   // configuration registers
   logic [bces_pkg::GEOM_BITS-1:0] width_ff, height_ff;
   logic [bces_pkg::SIZE_BITS-1:0] size_ff;
   logic [bces_pkg::THR_BITS-1:0]  thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bces_pkg::GEOM_BITS'(bces_pkg::WIDTH_RESET);
         height_ff <= bces_pkg::GEOM_BITS'(bces_pkg::HEIGHT_RESET);
         size_ff   <= bces_pkg::SIZE_BITS'(bces_pkg::SIZE_RESET);
         thr_ff    <= bces_pkg::THR_BITS'(bces_pkg::THR_RESET);
      end else if (csr_valid && csr_ready) begin
         unique case (bces_pkg::csr_index_type'(csr_addr))
            bces_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[bces_pkg::GEOM_BITS-1:0];
            bces_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata[bces_pkg::GEOM_BITS-1:0];
            bces_pkg::CSR_WINDOW_SIZE:  size_ff   <= csr_wdata[bces_pkg::SIZE_BITS-1:0];
            bces_pkg::CSR_THRESHOLD:    thr_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // front -> queue
   bces_pkg::item_flags_type f_flags, b_flags;
   logic                     f_push, q_full, q_valid, b_pop;
   logic [PIXEL_BITS-1:0]    f_pix, b_pix;
   logic [CW-1:0]            f_col, b_col;
   logic [RAW-1:0]           f_wr, f_rd, b_wr, b_rd;
   logic [KW-1:0]            f_rk, f_ok, b_rk, b_ok;
   logic [CB-1:0]            f_row, f_ocol, b_row, b_ocol;
   logic [bces_pkg::THR_BITS-1:0] f_thr, b_thr;
   logic [2*SW-1:0]          f_s2, b_s2;
   logic [QW-1:0]            q_in, q_head;

   bces_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_WINDOW(MAX_WINDOW),
      .PIXEL_BITS(PIXEL_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .pixel        (req_tdata[PIXEL_BITS-1:0]),
      .frame_start  (req_tuser),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .window_size  (size_ff),
      .threshold_q16(thr_ff),
      .queue_full   (q_full),
      .push         (f_push),
      .flags        (f_flags),
      .pix          (f_pix),
      .col          (f_col),
      .wr_addr      (f_wr),
      .rd_addr      (f_rd),
      .rk           (f_rk),
      .ok           (f_ok),
      .out_row      (f_row),
      .out_col      (f_ocol),
      .thr          (f_thr),
      .s2           (f_s2)
   );

   assign q_in = {f_flags, f_pix, f_col, f_wr, f_rd, f_rk, f_ok, f_row, f_ocol, f_thr, f_s2};

   bces_queue #(.WIDTH(QW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .push_data(q_in),
      .full     (q_full),
      .pop      (b_pop),
      .not_empty(q_valid),
      .head     (q_head)
   );

   assign {b_flags, b_pix, b_col, b_wr, b_rd, b_rk, b_ok, b_row, b_ocol, b_thr, b_s2} = q_head;

   logic          r_edge, r_done;
   logic [CB-1:0] r_row, r_col;

   bces_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_WINDOW(MAX_WINDOW),
      .PIXEL_BITS(PIXEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .item_valid(q_valid),
      .pop       (b_pop),
      .flags     (b_flags),
      .pix       (b_pix),
      .col       (b_col),
      .wr_addr   (b_wr),
      .rd_addr   (b_rd),
      .rk        (b_rk),
      .ok        (b_ok),
      .out_row   (b_row),
      .out_col   (b_ocol),
      .thr       (b_thr),
      .s2        (b_s2),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_edge  (r_edge),
      .rsp_row   (r_row),
      .rsp_col   (r_col),
      .rsp_done  (r_done)
   );

   assign rsp_tdata = bces_pkg::RSP_DATA_BITS'({r_col, r_row, r_edge});
   assign rsp_tlast = r_done;

endmodule

// File: dv/box_contrast_edge_segmenter_unit_tb.sv
`timescale 1ns / 100ps

module box_contrast_edge_segmenter_unit_tb;

   // pixels sent by the random part of the run
   localparam int unsigned RANDOM_ITEMS = 1150;

   // one pixel word as queued for the driver
   typedef struct {
      logic [7:0] pix;
      logic       start;
   } pixel_word_type;

   // one expected window verdict: packed rsp word plus the frame-done flag
   typedef struct {
      logic [bces_pkg::RSP_DATA_BITS-1:0] word;
      logic                               done;
   } window_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [7:0]                         req_tdata  = '0;   // [7:0] pixel
   logic                               req_tuser  = 1'b0; // [0] frame_start
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   // [0] edge_res, [10:1] out_row, [20:11] out_col
   logic [bces_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tlast;         // [0] frame_done
   logic                               csr_valid  = 1'b0;
   logic                               csr_ready;
   logic [bces_pkg::CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [bces_pkg::THR_BITS-1:0]      csr_wdata  = '0;

   box_contrast_edge_segmenter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow of the block: registers and segmentation state
   // ------------------------------------------------------------------
   int unsigned cfg_width  = bces_pkg::WIDTH_RESET;
   int unsigned cfg_height = bces_pkg::HEIGHT_RESET;
   int unsigned cfg_side   = bces_pkg::SIZE_RESET;
   int unsigned cfg_thr    = bces_pkg::THR_RESET;

   bit [7:0]          line_rows [14*1024];  // never-written entries read as zero
   longint unsigned   col_sum [1024];
   longint unsigned   col_sq [1024];
   longint unsigned   recent_sum [15];
   longint unsigned   recent_sq [15];
   longint unsigned   win_sum = 0;
   longint unsigned   win_sq  = 0;
   int unsigned       cur_row = 0;
   int unsigned       cur_col = 0;
   int unsigned       held_side = 0;

   pixel_word_type     pixel_backlog[$];
   window_verdict_type window_verdicts[$];

   int unsigned idle_mode   = 0;   // 0: sender 33/rx 60, 1: swapped, 2: no idling
   int unsigned mismatches  = 0;
   int unsigned csr_writes  = 0;

   // Per-pixel segmentation step; pushes the verdict when a window completes.
   function automatic void segment_pixel(logic [7:0] pix_in, logic start);
      longint unsigned pix, full, fullq, old, lhs, rhs, thr;
      int unsigned w, h, r, c, s, cidx, slot, rk, ok, half;
      window_verdict_type v;
      pix = pix_in;
      w = (cfg_width == 0) ? 1 : (cfg_width > 1024 ? 1024 : cfg_width);
      h = (cfg_height == 0) ? 1 : (cfg_height > 1024 ? 1024 : cfg_height);
      if (start) begin
         cur_row = 0;
         cur_col = 0;
      end
      r = cur_row;
      c = cur_col;
      // window side latched at the first pixel of each frame
      if (r == 0 && c == 0) held_side = (cfg_side > 15) ? 15 : cfg_side;
      s = held_side;
      cidx = c % 1024;
      if (s > 0) begin
         // row 0 ignores stale column sums, which clears them per frame
         full  = ((r == 0) ? 0 : col_sum[cidx]) + pix;
         fullq = ((r == 0) ? 0 : col_sq[cidx]) + pix * pix;
         slot  = (r % 14) * 1024 + cidx;
         rk    = c % 15;
         if (r + 1 >= s) begin
            old = (s == 1) ? pix : line_rows[((r + 1 - s) % 14) * 1024 + cidx];
            col_sum[cidx] = full - old;
            col_sq[cidx]  = fullq - old * old;
         end else begin
            col_sum[cidx] = full;
            col_sq[cidx]  = fullq;
         end
         line_rows[slot] = pix[7:0];
         if (c == 0) begin
            win_sum = 0;
            win_sq  = 0;
         end
         recent_sum[rk] = full;
         recent_sq[rk]  = fullq;
         win_sum += full;
         win_sq  += fullq;
         if (c + 1 >= s) begin
            ok = (c + 1 - s) % 15;
            if (r + 1 >= s) begin
               half = (s - 1) / 2;
               thr  = (cfg_thr > bces_pkg::THR_ONE) ? bces_pkg::THR_ONE : cfg_thr;
               lhs  = (win_sum * win_sum) << bces_pkg::Q_FRAC;
               rhs  = thr * s * s * win_sq;
               v.word = '0;
               v.word[0]     = (lhs < rhs);
               v.word[10:1]  = 10'(r + 1 - s + half);
               v.word[20:11] = 10'(c + 1 - s + half);
               v.done = (r + 1 >= h && c + 1 >= w);
               window_verdicts.push_back(v);
            end
            win_sum -= recent_sum[ok];
            win_sq  -= recent_sq[ok];
         end
      end
      if (c + 1 >= w) begin
         cur_col = 0;
         cur_row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         cur_col = c + 1;
      end
   endfunction

   function automatic int unsigned send_idle_pct();
      return (idle_mode == 0) ? 33 : (idle_mode == 1) ? 60 : 0;
   endfunction

   function automatic int unsigned recv_idle_pct();
      return (idle_mode == 0) ? 60 : (idle_mode == 1) ? 33 : 0;
   endfunction

   // ------------------------------------------------------------------
   // Pixel driver; the shadow steps on every accepted word
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_word_type pw;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) segment_pixel(req_tdata, req_tuser);
         if (!req_tvalid || req_tready) begin
            if (pixel_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
               pw = pixel_backlog.pop_front();
               req_tdata  <= pw.pix;
               req_tuser  <= pw.start;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result side backpressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct());
   end

   // Result checker: each accepted word against the oldest verdict
   always @(posedge clock) begin
      window_verdict_type v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (window_verdicts.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result word %h last %b", rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            v = window_verdicts.pop_front();
            if (rsp_tdata !== v.word || rsp_tlast !== v.done) begin
               if (mismatches < 10)
                  $display({"mismatch: exp edge %b row %0d col %0d last %b",
                            " / got edge %b row %0d col %0d last %b (word %h)"},
                           v.word[0], v.word[10:1], v.word[20:11], v.done,
                           rsp_tdata[0], rsp_tdata[10:1], rsp_tdata[20:11], rsp_tlast,
                           rsp_tdata);
               mismatches++;
            end
         end
      end
   end

   // Register writes land in the shadow on the accepting edge
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         case (bces_pkg::csr_index_type'(csr_addr))
            bces_pkg::CSR_FRAME_WIDTH:  cfg_width  = csr_wdata & 17'h7FF;
            bces_pkg::CSR_FRAME_HEIGHT: cfg_height = csr_wdata & 17'h7FF;
            bces_pkg::CSR_WINDOW_SIZE:  cfg_side   = csr_wdata & 17'hF;
            bces_pkg::CSR_THRESHOLD:    cfg_thr    = csr_wdata;
            default: ;
         endcase
         csr_valid  <= 1'b0;
         csr_writes <= csr_writes + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic write_reg(bces_pkg::csr_index_type idx, int unsigned value);
      int unsigned target;
      target = csr_writes + 1;
      @(posedge clock);
      csr_addr  <= idx;
      csr_wdata <= value[bces_pkg::THR_BITS-1:0];
      csr_valid <= 1'b1;
      wait (csr_writes == target);
   endtask

   task automatic configure(int unsigned w, int unsigned h, int unsigned s, int unsigned thr);
      write_reg(bces_pkg::CSR_FRAME_WIDTH, w);
      write_reg(bces_pkg::CSR_FRAME_HEIGHT, h);
      write_reg(bces_pkg::CSR_WINDOW_SIZE, s);
      write_reg(bces_pkg::CSR_THRESHOLD, thr);
   endtask

   // pattern: 0 random, 1 flat with small noise, 2 vertical step, 3 checkerboard
   task automatic queue_pixels(int unsigned w, int unsigned count, int unsigned pattern,
                               bit first_start);
      pixel_word_type pw;
      int unsigned base, col, row;
      base = $urandom_range(255);
      @(negedge clock);
      for (int unsigned i = 0; i < count; i++) begin
         col = i % w;
         row = i / w;
         case (pattern)
            0: pw.pix = 8'($urandom_range(255));
            1: pw.pix = 8'(base + $urandom_range(2));
            2: pw.pix = (col < w / 2) ? 8'(base) : 8'(~base);
            default: pw.pix = ((col + row) % 2) ? 8'hFF : 8'h00;
         endcase
         pw.start = (i == 0) && first_start;
         pixel_backlog.push_back(pw);
      end
   endtask

   // drain everything, then cover results still in the pipeline
   task automatic settle();
      do @(negedge clock);
      while (pixel_backlog.size() != 0 || req_tvalid || window_verdicts.size() != 0);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      int unsigned pushed, w, h, s, thr, nfr, cnt, pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // full threshold: a flat window sits exactly on the boundary -> background
      configure(3, 3, 3, bces_pkg::THR_ONE);
      queue_pixels(3, 9, 3, 1);              // checkerboard of 0 and 255
      queue_pixels(3, 9, 1, 1);
      settle();
      // zero window: nothing emitted
      configure(4, 3, 0, 0);
      queue_pixels(4, 12, 0, 1);
      settle();
      // window larger than frame: nothing emitted
      configure(2, 2, 15, 131071);
      queue_pixels(2, 4, 0, 1);
      settle();
      // zero geometry treated as 1x1; each pixel is its own frame
      configure(0, 0, 1, 0);
      queue_pixels(1, 5, 0, 1);
      settle();
      // even window side
      configure(5, 4, 4, 50000);
      queue_pixels(5, 20, 0, 1);
      settle();
      // width lowered mid-row: the row ends at once, frame continues
      configure(6, 6, 3, 40000);
      queue_pixels(6, 15, 0, 1);
      settle();
      write_reg(bces_pkg::CSR_FRAME_WIDTH, 3);
      queue_pixels(3, 10, 0, 0);
      settle();

      // --- random frames, idling modes in thirds ---
      pushed = 0;
      while (pushed < RANDOM_ITEMS) begin
         idle_mode = (pushed < RANDOM_ITEMS / 3) ? 0
                   : (pushed < 2 * RANDOM_ITEMS / 3) ? 1 : 2;
         pick = $urandom_range(99);
         if (pick < 70)      s = 2 * $urandom_range(7) + 1;
         else if (pick < 88) s = 2 * $urandom_range(1, 7);
         else                s = 0;
         w = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, s + 8);
         h = $urandom_range(1, s + 4);
         pick = $urandom_range(9);
         thr = (pick == 0) ? 0 : (pick == 1) ? bces_pkg::THR_ONE : (pick == 2) ? 131071
             : $urandom_range(bces_pkg::THR_ONE);
         configure(w, h, s, thr);
         nfr = $urandom_range(1, 3);
         for (int unsigned f = 0; f < nfr && pushed < RANDOM_ITEMS; f++) begin
            cnt = ($urandom_range(9) == 0) ? $urandom_range(1, w * h) : w * h;
            if (cnt > RANDOM_ITEMS - pushed) cnt = RANDOM_ITEMS - pushed;
            queue_pixels(w, cnt, $urandom_range(3), 1);
            pushed += cnt;
         end
         settle();
      end

      // --- geometry above range, fast stream ---
      idle_mode = 2;
      configure(2047, 2, 1, 30000);          // width clamps to the line length
      queue_pixels(1024, 40, 0, 1);
      settle();
      configure(1, 2047, 1, 65535);          // height clamps
      queue_pixels(1, 40, 0, 1);
      settle();

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #(8 * 2000000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
